### src/i2c_transaction_queue_sequencer_top_macros.svh
// Assertion macros for the I2C transaction queue sequencer.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef I2C_TRANSACTION_QUEUE_SEQUENCER_TOP_MACROS_SVH
`define I2C_TRANSACTION_QUEUE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ITQS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ITQS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/itqs_pkg.sv
// Package of the I2C transaction queue sequencer: payload structs, codes,
// default sizes and shared helpers. No dependencies.
`timescale 1ns / 1ps

package itqs_pkg;

    localparam int RING_BYTES_DEF       = 64;
    localparam int MAX_RECORD_BYTES_DEF = 5;
    localparam int KEPT_BYTES           = 5;   // bytes of a record that are issued
    localparam int QUEUE_USED_W         = 7;

    localparam logic [2:0] MAX_WRITE_DATA = 3'd4;

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // request status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    // read status codes
    localparam logic [1:0] RD_BUSY  = 2'd0;
    localparam logic [1:0] RD_DONE  = 2'd1;
    localparam logic [1:0] RD_ERROR = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [31:0] data_bytes;
        logic [2:0]  write_count;
        logic [7:0]  read_length;
        logic        bus_idle;
        logic        tx_ok;
        logic        rx_start_ok;
    } req_t;

    typedef struct packed {
        logic [1:0]                  req_status;
        logic                        issue_write;
        logic                        issue_read;
        logic [7:0]                  out_dev_addr;
        logic [7:0]                  out_reg_addr;
        logic [7:0]                  out_length;
        logic [8*KEPT_BYTES-1:0]     out_bytes;
        logic [1:0]                  read_state;
        logic [QUEUE_USED_W-1:0]     queue_used;
    } rsp_t;

    // record taken out of the ring
    typedef struct packed {
        logic [7:0]              dev;
        logic [7:0]              len;
        logic [8*KEPT_BYTES-1:0] bytes;
    } rec_t;

    // record to put into the ring
    typedef struct packed {
        logic [7:0]  dev;
        logic [7:0]  reg_addr;
        logic [31:0] data;
        logic [2:0]  cnt;
    } put_t;

    typedef struct packed {
        logic put;
        logic take;
    } ring_cmd_t;

    typedef struct packed {
        logic done;
        logic nonempty;
        logic fits;
    } ring_stat_t;

    function automatic logic [2:0] clamp_count(input logic [2:0] cnt);
        return (cnt > MAX_WRITE_DATA) ? MAX_WRITE_DATA : cnt;
    endfunction

endpackage

### src/itqs_ram.sv
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module itqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = itqs_pkg::RING_BYTES_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/itqs_ring.sv
// Byte ring of the sequencer: pointers, fill count and the put/take sequencer
// around one itqs_ram instance. Depends on itqs_pkg and itqs_ram.
`timescale 1ns / 1ps

module itqs_ring #(
    parameter int RING_BYTES       = itqs_pkg::RING_BYTES_DEF,
    parameter int MAX_RECORD_BYTES = itqs_pkg::MAX_RECORD_BYTES_DEF,
    localparam int UW = $clog2(RING_BYTES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  itqs_pkg::ring_cmd_t  cmd,
    input  itqs_pkg::put_t       put,     // hold stable while a put runs
    output itqs_pkg::ring_stat_t stat,
    output itqs_pkg::rec_t       rec,
    output logic [UW-1:0]        used
);

    localparam int AW = $clog2(RING_BYTES);
    localparam int BW = $clog2(MAX_RECORD_BYTES + 1);

    typedef enum logic [2:0] {
        R_IDLE,
        R_PUT,
        R_LEN,
        R_CNT,
        R_BYTE
    } ring_state_t;

    ring_state_t     state_reg, state_next;
    logic [AW-1:0]   wp_reg, wp_next;
    logic [AW-1:0]   rp_reg, rp_next;
    logic [UW-1:0]   used_reg, used_next;
    logic [2:0]      pidx_reg, pidx_next;
    logic [BW-1:0]   remain_reg, remain_next;
    logic [BW-1:0]   bidx_reg, bidx_next;
    itqs_pkg::rec_t  rec_reg, rec_next;
    logic            done_reg, done_next;

    logic            we;
    logic [7:0]      wdata;
    logic [7:0]      rdata;
    logic [AW-1:0]   wp_inc, rp_inc;
    logic [UW-1:0]   used_dec;
    logic [UW:0]     need;
    logic [1:0]      didx;

    itqs_ram #(
        .WIDTH (8),
        .DEPTH (RING_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wp_reg),
        .wdata (wdata),
        .raddr (rp_reg),
        .rdata (rdata)
    );

    assign wp_inc   = (wp_reg == AW'(RING_BYTES - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc   = (rp_reg == AW'(RING_BYTES - 1)) ? '0 : rp_reg + 1'b1;
    assign used_dec = (used_reg == '0) ? '0 : used_reg - 1'b1;
    // data byte index for record positions three to six
    assign didx     = pidx_reg[1:0] + 2'd1;
    assign need     = (UW+1)'(used_reg) + (UW+1)'(put.cnt) + (UW+1)'(3);

    always_comb
    begin
        logic [7:0] n_len;
        n_len       = '0;
        state_next  = state_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        used_next   = used_reg;
        pidx_next   = pidx_reg;
        remain_next = remain_reg;
        bidx_next   = bidx_reg;
        rec_next    = rec_reg;
        done_next   = 1'b0;
        we          = 1'b0;
        wdata       = '0;
        unique case (state_reg)
            R_IDLE:
            begin
                if (cmd.put)
                begin
                    we         = 1'b1;
                    wdata      = put.dev;
                    wp_next    = wp_inc;
                    used_next  = used_reg + 1'b1;
                    pidx_next  = 3'd1;
                    state_next = R_PUT;
                end
                else if (cmd.take)
                begin
                    // issue the device address read
                    rp_next    = rp_inc;
                    used_next  = used_dec;
                    rec_next   = '0;
                    state_next = R_LEN;
                end
            end
            R_PUT:
            begin
                we = 1'b1;
                case (pidx_reg)
                    3'd1:    wdata = {5'd0, put.cnt} + 8'd1;
                    3'd2:    wdata = put.reg_addr;
                    default: wdata = put.data[8*didx +: 8];
                endcase
                wp_next   = wp_inc;
                used_next = used_reg + 1'b1;
                if (pidx_reg == put.cnt + 3'd2)
                begin
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
                else
                begin
                    pidx_next = pidx_reg + 3'd1;
                end
            end
            R_LEN:
            begin
                rec_next.dev = rdata;
                rp_next      = rp_inc;
                used_next    = used_dec;
                state_next   = R_CNT;
            end
            R_CNT:
            begin
                n_len = (rdata > 8'(MAX_RECORD_BYTES)) ? 8'(MAX_RECORD_BYTES) : rdata;
                rec_next.len = n_len;
                if (n_len == 8'd0)
                begin
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
                else
                begin
                    rp_next     = rp_inc;
                    used_next   = used_dec;
                    remain_next = BW'(n_len - 8'd1);
                    bidx_next   = '0;
                    state_next  = R_BYTE;
                end
            end
            R_BYTE:
            begin
                for (int k = 0; k < itqs_pkg::KEPT_BYTES; k++)
                begin
                    if (int'(bidx_reg) == k)
                    begin
                        rec_next.bytes[8*k +: 8] = rdata;
                    end
                end
                bidx_next = bidx_reg + 1'b1;
                if (remain_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
                else
                begin
                    rp_next     = rp_inc;
                    used_next   = used_dec;
                    remain_next = remain_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= R_IDLE;
            wp_reg     <= '0;
            rp_reg     <= '0;
            used_reg   <= '0;
            pidx_reg   <= '0;
            remain_reg <= '0;
            bidx_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            used_reg   <= used_next;
            pidx_reg   <= pidx_next;
            remain_reg <= remain_next;
            bidx_reg   <= bidx_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign stat.done     = done_reg;
    assign stat.nonempty = (used_reg != '0);
    assign stat.fits     = (used_reg <= UW'(RING_BYTES)) && (need <= (UW+1)'(RING_BYTES));
    assign rec           = rec_reg;
    assign used          = used_reg;

endmodule

### src/itqs_ctrl.sv
// Transmit and receive machines with the shared bus-busy flag and the held
// write and read transactions. Depends on itqs_pkg and the macros header.
`timescale 1ns / 1ps
`include "i2c_transaction_queue_sequencer_top_macros.svh"

module itqs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            apply,     // commit the step of the current request
    input  itqs_pkg::req_t  req,
    input  logic            refuse,    // write did not fit the ring
    input  logic            nonempty,
    input  itqs_pkg::rec_t  rec,       // record taken for a transmit start
    output logic            tx_start,
    output itqs_pkg::rsp_t  step
);

    typedef enum logic [2:0] {
        TX_IDLE,
        TX_BUS_READY,
        TX_START,
        TX_BUS_FREE,
        TX_RETRANS,
        TX_END
    } tx_phase_t;

    typedef enum logic [2:0] {
        RX_IDLE,
        RX_BUS_READY,
        RX_START,
        RX_WAIT,
        RX_END
    } rx_phase_t;

    typedef struct packed {
        logic [7:0] dev;
        logic [7:0] reg_addr;
        logic [7:0] len;
    } read_hold_t;

    tx_phase_t       tx_reg, tx_next;
    rx_phase_t       rx_reg, rx_next;
    logic            busy_reg, busy_next;
    itqs_pkg::rec_t  hw_reg, hw_next;
    read_hold_t      hr_reg, hr_next;
    logic [1:0]      last_reg, last_next;

    always_comb
    begin
        tx_next   = tx_reg;
        rx_next   = rx_reg;
        busy_next = busy_reg;
        hw_next   = hw_reg;
        hr_next   = hr_reg;
        last_next = last_reg;
        step      = '0;
        if (req.req_type == itqs_pkg::REQ_WRITE)
        begin
            step.req_status = refuse ? itqs_pkg::ST_FULL : itqs_pkg::ST_OK;
        end
        else if (req.req_type == itqs_pkg::REQ_READ)
        begin
            if (rx_reg == RX_IDLE && !busy_reg)
            begin
                hr_next   = '{dev: req.dev_addr, reg_addr: req.reg_addr,
                              len: req.read_length};
                last_next = itqs_pkg::RD_BUSY;
                rx_next   = RX_BUS_READY;
                busy_next = 1'b1;
            end
            else
            begin
                step.req_status = itqs_pkg::ST_BUSY;
            end
        end
        else if (req.req_type == itqs_pkg::REQ_TICK)
        begin
            // transmit side first
            unique case (tx_reg)
                TX_IDLE:
                begin
                    if (nonempty && !busy_reg)
                    begin
                        busy_next = 1'b1;
                        tx_next   = TX_BUS_READY;
                    end
                end
                TX_BUS_READY:
                begin
                    if (req.bus_idle)
                    begin
                        tx_next = TX_START;
                    end
                end
                TX_START:
                begin
                    hw_next          = rec;
                    step.issue_write = 1'b1;
                    tx_next          = req.tx_ok ? TX_END : TX_BUS_FREE;
                end
                TX_BUS_FREE:
                begin
                    if (req.bus_idle)
                    begin
                        tx_next = TX_RETRANS;
                    end
                end
                TX_RETRANS:
                begin
                    step.issue_write = 1'b1;
                    tx_next          = TX_END;
                end
                TX_END:
                begin
                    busy_next = 1'b0;
                    tx_next   = TX_IDLE;
                end
                default:
                begin
                    tx_next = TX_IDLE;
                end
            endcase
            if (step.issue_write)
            begin
                step.out_dev_addr = hw_next.dev;
                step.out_length   = hw_next.len;
                step.out_bytes    = hw_next.bytes;
                step.out_reg_addr = hw_next.bytes[7:0];
            end

            // then the receive side
            unique case (rx_reg)
                RX_IDLE:
                begin
                end
                RX_BUS_READY:
                begin
                    if (req.bus_idle)
                    begin
                        rx_next = RX_START;
                    end
                end
                RX_START:
                begin
                    step.issue_read = 1'b1;
                    if (req.rx_start_ok)
                    begin
                        rx_next = RX_WAIT;
                    end
                    else
                    begin
                        last_next = itqs_pkg::RD_ERROR;
                        rx_next   = RX_END;
                    end
                end
                RX_WAIT:
                begin
                    if (req.bus_idle)
                    begin
                        last_next = itqs_pkg::RD_DONE;
                        rx_next   = RX_END;
                    end
                end
                RX_END:
                begin
                    busy_next = 1'b0;
                    rx_next   = RX_IDLE;
                end
                default:
                begin
                    rx_next = RX_IDLE;
                end
            endcase
            if (step.issue_read)
            begin
                step.out_dev_addr = hr_reg.dev;
                step.out_reg_addr = hr_reg.reg_addr;
                step.out_length   = hr_reg.len;
                step.out_bytes    = '0;
            end
        end
        step.read_state = last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_reg   <= TX_IDLE;
            rx_reg   <= RX_IDLE;
            busy_reg <= 1'b0;
            hw_reg   <= '0;
            hr_reg   <= '0;
            last_reg <= itqs_pkg::RD_BUSY;
        end
        else if (apply)
        begin
            tx_reg   <= tx_next;
            rx_reg   <= rx_next;
            busy_reg <= busy_next;
            hw_reg   <= hw_next;
            hr_reg   <= hr_next;
            last_reg <= last_next;
        end
    end

    assign tx_start = (tx_reg == TX_START);

    // only one machine owns the bus, so a step never issues both kinds
    `ITQS_ASSERT_IMP(a_one_issue, apply, $onehot0({step.issue_write, step.issue_read}),
        "write and read issued in one step")
    `ITQS_ASSERT_IMP(a_tx_owns_bus, tx_reg != TX_IDLE, busy_reg,
        "transmit machine active without the bus")
    `ITQS_ASSERT_IMP(a_rx_owns_bus, rx_reg != RX_IDLE, busy_reg,
        "receive machine active without the bus")

endmodule

### src/i2c_transaction_queue_sequencer_top.sv
// Top level of the I2C transaction queue sequencer: request handshake,
// dispatch and result register. Depends on itqs_pkg, itqs_ring, itqs_ctrl.
`timescale 1ns / 1ps
`include "i2c_transaction_queue_sequencer_top_macros.svh"

// Usage
//   req/req_valid/req_ready carries one transaction: a write record to queue,
//   a read to post, or a service tick that steps the transmit machine and
//   then the receive machine. rsp/rsp_valid/rsp_ready returns exactly one
//   result per transaction, in order.
//   Transactions are handled one at a time. A read, a refused write, a tick
//   without a record take or an unknown code goes from dispatch straight to
//   the result commit; a queued write or a tick that takes a record first
//   waits in the ring state while the ring moves its bytes. The next
//   transaction can be accepted in the cycle after the result is committed.
//   The ring memory has a single write port and a registered read path, and
//   one ring byte moves per cycle.
//   The result sits in an output register, so the next transaction is
//   accepted while a result still waits; a stalled rsp_ready holds only the
//   final commit of the following transaction.
//   Reset (rst_n low, asynchronous) empties the ring, idles both machines,
//   frees the bus and clears the read status. The ring contents are not
//   cleared; only bytes written since reset are ever read.
module i2c_transaction_queue_sequencer_top #(
    parameter int RING_BYTES       = itqs_pkg::RING_BYTES_DEF,
    parameter int MAX_RECORD_BYTES = itqs_pkg::MAX_RECORD_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  itqs_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output itqs_pkg::rsp_t  rsp
);

    localparam int UW = $clog2(RING_BYTES + 1);
    localparam int QW = itqs_pkg::QUEUE_USED_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_RING,
        S_FINISH
    } top_state_t;

    top_state_t           state_reg, state_next;
    itqs_pkg::req_t       req_reg, req_next;
    logic                 refuse_reg, refuse_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    itqs_pkg::rsp_t       rsp_reg, rsp_next;

    itqs_pkg::ring_cmd_t  ring_cmd;
    itqs_pkg::ring_stat_t ring_stat;
    itqs_pkg::put_t       put;
    itqs_pkg::rec_t       rec;
    itqs_pkg::rsp_t       step;
    logic [UW-1:0]        used;
    logic                 tx_start;
    logic                 apply;

    // queue write fields from the held transaction, with the data count clamped
    assign put.dev      = req_reg.dev_addr;
    assign put.reg_addr = req_reg.reg_addr;
    assign put.data     = req_reg.data_bytes;
    assign put.cnt      = itqs_pkg::clamp_count(req_reg.write_count);

    itqs_ring #(
        .RING_BYTES       (RING_BYTES),
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ring_cmd),
        .put   (put),
        .stat  (ring_stat),
        .rec   (rec),
        .used  (used)
    );

    itqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .apply    (apply),
        .req      (req_reg),
        .refuse   (refuse_reg),
        .nonempty (ring_stat.nonempty),
        .rec      (rec),
        .tx_start (tx_start),
        .step     (step)
    );

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        refuse_next    = refuse_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ring_cmd       = '0;
        apply          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                // hold the transaction for the whole of its handling
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                refuse_next = 1'b0;
                if (req_reg.req_type == itqs_pkg::REQ_WRITE)
                begin
                    // decide the full check before the fill count moves
                    refuse_next = !ring_stat.fits;
                    if (ring_stat.fits)
                    begin
                        ring_cmd.put = 1'b1;
                        state_next   = S_RING;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (req_reg.req_type == itqs_pkg::REQ_TICK && tx_start)
                begin
                    ring_cmd.take = 1'b1;
                    state_next    = S_RING;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_RING:
            begin
                if (ring_stat.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // commit only once the result register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    apply               = 1'b1;
                    rsp_next            = step;
                    rsp_next.queue_used = QW'(used);
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            refuse_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            refuse_reg    <= refuse_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ITQS_ASSERT_IMP(a_done_in_ring, ring_stat.done, state_reg == S_RING,
        "ring finished outside a ring wait")
    `ITQS_ASSERT_IMP(a_take_nonempty, ring_cmd.take, ring_stat.nonempty,
        "record take from an empty ring")
    `ITQS_ASSERT_IMP(a_used_bound, 1'b1, used <= UW'(RING_BYTES),
        "ring fill count above capacity")
    `ITQS_ASSERT_NXT(a_ring_wait, ring_cmd.put || ring_cmd.take, state_reg == S_RING,
        "ring started without waiting for it")

endmodule
